@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. Defining ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Property checked at every rising clk_i edge outside reset.
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, expr)
`endif

`endif

@@ rtl/msbu_pkg.sv @@
// ----------------------------------------------------------------------------
// msbu_pkg
// Constants and word types of the bottom-up merge sorter.
// ----------------------------------------------------------------------------
package msbu_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic                         last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] sorted_value;
    logic                         last_out;
    logic                         overflow;
  } out_t;

endpackage

@@ rtl/msbu_ram.sv @@
// ----------------------------------------------------------------------------
// msbu_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module msbu_ram #(
  parameter int Width = 32,
  parameter int Depth = 64,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

@@ rtl/merge_sort_bottom_up.sv @@
// ----------------------------------------------------------------------------
// merge_sort_bottom_up
// Batch sorter: loads signed words, sorts them by bottom-up merging, emits them.
// ----------------------------------------------------------------------------
// Words are loaded one per cycle into a first RAM until a word marked last
// arrives; words beyond Capacity are dropped and every result of that batch
// carries the overflow flag. The sort then runs ceil(log2(n)) merge passes
// that ping-pong between two RAMs. In a pass, each cycle compares the two
// run heads presented on the two read ports of the source RAM and writes the
// smaller one (the left run on ties) to the other RAM. The sorted batch then
// streams out at one word per cycle while the output is not stalled. No new
// word is taken while a batch is being sorted or emitted.
`include "assert_macros.svh"

module merge_sort_bottom_up import msbu_pkg::*; #(
  parameter int Capacity = CAPACITY
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int CntW = $clog2(Capacity + 1);
  localparam int IdxW = $clog2(Capacity);
  localparam int SumW = CntW + 2;

  typedef enum logic [1:0] {
    StLoad,
    StPass,
    StMerge,
    StOut
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] a_ptr_q, a_ptr_d;
  logic [CntW-1:0] b_ptr_q, b_ptr_d;
  logic [CntW-1:0] k_q, k_d;
  logic [CntW-1:0] mid_q, mid_d;
  logic [CntW-1:0] hi_q, hi_d;
  logic [CntW:0]   width_q, width_d;
  logic            src_q, src_d;
  logic            ovf_q, ovf_d;
  logic            ov_q, ov_d;
  out_t            out_q, out_d;

  logic                         in_acc;
  logic                         room;
  logic                         ld;
  logic                         take_a;
  logic                         a_ok, b_ok;
  logic signed [DATA_WIDTH-1:0] rd_a, rd_b, merged;
  logic [DATA_WIDTH-1:0]        r0_a, r0_b, r1_a, r1_b;
  logic [SumW-1:0]              base, sum_mid, sum_hi, n_ext;
  logic [CntW-1:0]              mid_new, hi_new;
  logic                         we0, we1;
  logic [IdxW-1:0]              w0_addr;
  logic [DATA_WIDTH-1:0]        w0_data;

  assign in_stall_o  = (state_q != StLoad);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign room        = (cnt_q < CntW'(Capacity));
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign ld          = (state_q == StOut) && (!ov_q || !out_stall_i);

  // Run heads come straight from the source RAM's read ports.
  assign rd_a   = src_q ? r1_a : r0_a;
  assign rd_b   = src_q ? r1_b : r0_b;
  assign a_ok   = (a_ptr_q < mid_q);
  assign b_ok   = (b_ptr_q < hi_q);
  assign take_a = a_ok && (!b_ok || (rd_a <= rd_b));
  assign merged = take_a ? rd_a : rd_b;

  // Bounds of the next pair of runs, clipped to the batch size.
  assign base    = (state_q == StPass) ? '0 : SumW'(hi_q);
  assign sum_mid = base + SumW'(width_q);
  assign sum_hi  = sum_mid + SumW'(width_q);
  assign n_ext   = SumW'(n_q);
  assign mid_new = (sum_mid < n_ext) ? sum_mid[CntW-1:0] : n_q;
  assign hi_new  = (sum_hi < n_ext) ? sum_hi[CntW-1:0] : n_q;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    n_d     = n_q;
    a_ptr_d = a_ptr_q;
    b_ptr_d = b_ptr_q;
    k_d     = k_q;
    mid_d   = mid_q;
    hi_d    = hi_q;
    width_d = width_q;
    src_d   = src_q;
    ovf_d   = ovf_q;
    ov_d    = ov_q && out_stall_i;
    out_d   = out_q;
    case (state_q)
      StLoad: begin
        if (in_acc) begin
          if (room) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          if (in_data_i.last) begin
            n_d     = room ? cnt_q + 1'b1 : cnt_q;
            cnt_d   = '0;
            width_d = (CntW + 1)'(1);
            src_d   = 1'b0;
            state_d = StPass;
          end
        end
      end
      StPass: begin
        a_ptr_d = '0;
        if (SumW'(width_q) >= n_ext) begin
          state_d = StOut;
        end else begin
          mid_d   = mid_new;
          hi_d    = hi_new;
          b_ptr_d = mid_new;
          k_d     = '0;
          state_d = StMerge;
        end
      end
      StMerge: begin
        k_d = k_q + 1'b1;
        if (take_a) begin
          a_ptr_d = a_ptr_q + 1'b1;
        end else begin
          b_ptr_d = b_ptr_q + 1'b1;
        end
        if (k_d == hi_q) begin
          if (hi_q == n_q) begin
            width_d = width_q << 1;
            src_d   = !src_q;
            state_d = StPass;
          end else begin
            // The next pair of runs starts where this one ended.
            mid_d   = mid_new;
            hi_d    = hi_new;
            a_ptr_d = hi_q;
            b_ptr_d = mid_new;
          end
        end
      end
      StOut: begin
        if (ld) begin
          ov_d               = 1'b1;
          out_d.sorted_value = rd_a;
          out_d.last_out     = (a_ptr_q + 1'b1 == n_q);
          out_d.overflow     = ovf_q;
          a_ptr_d            = a_ptr_q + 1'b1;
          if (out_d.last_out) begin
            ovf_d   = 1'b0;
            state_d = StLoad;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      cnt_q   <= '0;
      n_q     <= '0;
      a_ptr_q <= '0;
      b_ptr_q <= '0;
      k_q     <= '0;
      mid_q   <= '0;
      hi_q    <= '0;
      width_q <= '0;
      src_q   <= 1'b0;
      ovf_q   <= 1'b0;
      ov_q    <= 1'b0;
      out_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
      a_ptr_q <= a_ptr_d;
      b_ptr_q <= b_ptr_d;
      k_q     <= k_d;
      mid_q   <= mid_d;
      hi_q    <= hi_d;
      width_q <= width_d;
      src_q   <= src_d;
      ovf_q   <= ovf_d;
      ov_q    <= ov_d;
      out_q   <= out_d;
    end
  end

  // The first RAM takes loaded words and the output of passes that read the second.
  assign we0     = (in_acc && room) || ((state_q == StMerge) && src_q);
  assign we1     = (state_q == StMerge) && !src_q;
  assign w0_addr = (state_q == StLoad) ? cnt_q[IdxW-1:0] : k_q[IdxW-1:0];
  assign w0_data = (state_q == StLoad) ? in_data_i.value : merged;

  msbu_ram #(
    .Width(DATA_WIDTH),
    .Depth(Capacity)
  ) u_ram0 (
    .clk_i    (clk_i),
    .we_i     (we0),
    .waddr_i  (w0_addr),
    .wdata_i  (w0_data),
    .raddr_a_i(a_ptr_d[IdxW-1:0]),
    .raddr_b_i(b_ptr_d[IdxW-1:0]),
    .rdata_a_o(r0_a),
    .rdata_b_o(r0_b)
  );

  msbu_ram #(
    .Width(DATA_WIDTH),
    .Depth(Capacity)
  ) u_ram1 (
    .clk_i    (clk_i),
    .we_i     (we1),
    .waddr_i  (k_q[IdxW-1:0]),
    .wdata_i  (merged),
    .raddr_a_i(a_ptr_d[IdxW-1:0]),
    .raddr_b_i(b_ptr_d[IdxW-1:0]),
    .rdata_a_o(r1_a),
    .rdata_b_o(r1_b)
  );

  // Every word written so far in a merge came from exactly one of the two runs.
  `ASSERT_CLK(a_merge_count, (state_q == StMerge) |->
      (SumW'(k_q) + SumW'(mid_q) == SumW'(a_ptr_q) + SumW'(b_ptr_q)))
  `ASSERT_CLK(a_merge_bounds, (state_q == StMerge) |->
      (k_q < hi_q && a_ptr_q <= mid_q && b_ptr_q <= hi_q && hi_q <= n_q))
  `ASSERT_NEVER(a_count_range, cnt_q > CntW'(Capacity))
  `ASSERT_CLK(a_last_ends, (ld && out_d.last_out) |=> (state_q == StLoad && cnt_q == '0))

endmodule
